@@ hw/rtl/chtkv_pkg.sv @@
`default_nettype none

package chtkv_pkg;

  // default table geometry
  localparam int BUCKETS_DEF    = 16;
  localparam int WAYS_DEF       = 4;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths on the ports
  localparam int TYPE_W  = 2;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 7;

  // request codes
  typedef enum logic [TYPE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_UPDATED   = 3'd1,
    STS_FOUND     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_REMOVED   = 3'd4,
    STS_FULL      = 3'd5,
    STS_CLEARED   = 3'd6
  } status_e_t;

  // input item
  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [KEY_W-1:0]   req_key;
    logic [VALUE_W-1:0] req_value;
  } req_t;

  // result item
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] found_value;
    logic [COUNT_W-1:0] entry_count;
    logic               table_empty;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;    // latch request, start bucket index
    logic hash_step;  // one remainder step of the bucket index
    logic rd_in;      // read bucket row addressed by incoming key
    logic rd_hold;    // read bucket row addressed by latched bucket
    logic exec;       // compare, write back, load result
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hash_done;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/chained_hash_table_kv.sv @@
// flow: when BUCKETS is a power of two the bucket row is read at accept, then compare and
// write back run once the result register is free; otherwise the key modulo BUCKETS is first
// computed by reciprocal multiply (multiply, add and shift, subtract), then the row is read
// a new item waits until the last one is executed; a result not yet taken holds the next compare
// reset: synchronous active-low rst_n clears all valid bits and the entry count
`default_nettype none

module chained_hash_table_kv import chtkv_pkg::*; #(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int WAYS       = WAYS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  chtkv_ctrl #(
    .BUCKETS (BUCKETS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table storage and compare
  chtkv_dp #(
    .BUCKETS    (BUCKETS),
    .WAYS       (WAYS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ hw/rtl/chtkv_ctrl.sv @@
`default_nettype none

module chtkv_ctrl import chtkv_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HASH = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (POW2) begin
            cmd.rd_in = 1'b1;
            state_nxt = ST_EXEC;
          end else begin
            state_nxt = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (sts.hash_done) begin
          cmd.rd_hold = 1'b1;
          state_nxt   = ST_EXEC;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    priority if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/chtkv_dp.sv @@
`default_nettype none

module chtkv_dp import chtkv_pkg::*; #(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int WAYS       = WAYS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire req_t    in_data,
  input  wire dp_cmd_t cmd,
  output dp_sts_t      sts,
  output rsp_t         out_data
);

  localparam int  BW    = $clog2(BUCKETS);
  localparam int  KU    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int  VU    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int  KX    = (KU > BW) ? KU : BW;
  localparam int  SLOTS = BUCKETS * WAYS;
  localparam int  CW    = $clog2(SLOTS + 1);
  localparam bit  POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

  // latched request
  op_e_t                 op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [BW-1:0]         bucket_r;
  logic [KEY_BITS-1:0]   key_in;
  logic [VALUE_BITS-1:0] val_in;
  logic [BW-1:0]         in_bucket;
  logic [BW-1:0]         rd_addr;

  // bucket rows and per-slot state
  logic [WAYS*KEY_BITS-1:0]   key_mem [BUCKETS];
  logic [WAYS*VALUE_BITS-1:0] val_mem [BUCKETS];
  logic [WAYS*KEY_BITS-1:0]   key_row_r;
  logic [WAYS*VALUE_BITS-1:0] val_row_r;
  logic [WAYS-1:0]            valid_r [BUCKETS];
  logic [CW-1:0]              count_r;
  rsp_t                       out_r;

  // compare and update
  logic [WAYS-1:0]            valid_row;
  logic [WAYS-1:0]            valid_row_nxt;
  logic [WAYS-1:0]            hit;
  logic [WAYS-1:0]            hit_oh;
  logic [WAYS-1:0]            free_oh;
  logic [WAYS-1:0]            sel_oh;
  logic [VALUE_BITS-1:0]      found;
  logic [WAYS*KEY_BITS-1:0]   key_row_wr;
  logic [WAYS*VALUE_BITS-1:0] val_row_wr;
  logic                       key_we;
  logic                       val_we;
  logic                       clear_all;
  logic [CW-1:0]              count_nxt;
  status_e_t                  status;
  rsp_t                       rsp_nxt;

  assign key_in = KEY_BITS'(in_data.req_key[KU-1:0]);
  assign val_in = VALUE_BITS'(in_data.req_value[VU-1:0]);

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_e_t'(in_data.req_type);
      key_r <= key_in;
      val_r <= val_in;
    end
  end

  // bucket index: low key bits, or a remainder by reciprocal multiply
  generate
    if (POW2) begin : g_pow2
      logic [KX-1:0] key_x;
      assign key_x         = KX'(in_data.req_key[KU-1:0]);
      assign in_bucket     = key_x[BW-1:0];
      assign sts.hash_done = 1'b1;

      always_ff @(posedge clk) begin
        if (cmd.capture) begin
          bucket_r <= in_bucket;
        end
      end
    end else begin : g_mod
      // quotient = key * ceil(2^(KU+BW) / BUCKETS) >> (KU+BW); the multiplier's
      // top bit is always 2^KU, so only its low KU bits need a multiply
      localparam logic [63:0]   RECIP  = ((64'd1 << (KU + BW)) + 64'(BUCKETS) - 64'd1)
                                         / 64'(BUCKETS);
      localparam logic [KU-1:0] RCP_LO = RECIP[KU-1:0];
      localparam logic [BW-1:0] BK_LO  = BW'(BUCKETS);
      logic [KU-1:0]   kh_r;
      logic [2*KU-1:0] prod_r;
      logic [2*KU:0]   prod_sum;
      logic [KU-1:0]   quot_r;
      logic [KX-1:0]   kh_x;
      logic [KX-1:0]   quot_x;
      logic [BW-1:0]   quot_b;
      logic [1:0]      hc_r;

      assign in_bucket     = '0;
      assign prod_sum      = {1'b0, kh_r, {KU{1'b0}}} + {1'b0, prod_r};
      assign kh_x          = KX'(kh_r);
      assign quot_x        = KX'(quot_r);
      assign quot_b        = BW'(quot_x[BW-1:0] * BK_LO);
      assign sts.hash_done = (hc_r == 2'd0);

      // three steps: multiply, add and shift, then subtract
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          hc_r <= 2'd0;
        end else if (cmd.capture) begin
          hc_r <= 2'd3;
        end else if (cmd.hash_step) begin
          hc_r <= hc_r - 2'd1;
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.capture) begin
          kh_r <= in_data.req_key[KU-1:0];
        end
        if (cmd.hash_step && (hc_r == 2'd3)) begin
          prod_r <= kh_r * RCP_LO;
        end
        if (cmd.hash_step && (hc_r == 2'd2)) begin
          quot_r <= KU'(prod_sum >> (KU + BW));
        end
        if (cmd.hash_step && (hc_r == 2'd1)) begin
          bucket_r <= kh_x[BW-1:0] - quot_b;
        end
      end
    end
  endgenerate

  assign rd_addr = cmd.rd_in ? in_bucket : bucket_r;

  // bucket row memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_in || cmd.rd_hold) begin
      key_row_r <= key_mem[rd_addr];
      val_row_r <= val_mem[rd_addr];
    end
    if (cmd.exec && key_we) begin
      key_mem[bucket_r] <= key_row_wr;
    end
    if (cmd.exec && val_we) begin
      val_mem[bucket_r] <= val_row_wr;
    end
  end

  // way compare and lowest match / lowest free way
  always_comb begin
    valid_row = valid_r[bucket_r];
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = valid_row[w] && (key_row_r[w*KEY_BITS +: KEY_BITS] == key_r);
    end
    hit_oh  = hit & (~hit + WAYS'(1));
    free_oh = ~valid_row & (valid_row + WAYS'(1));
    sel_oh  = (|hit) ? hit_oh : free_oh;

    found      = '0;
    key_row_wr = key_row_r;
    val_row_wr = val_row_r;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) begin
        found = found | val_row_r[w*VALUE_BITS +: VALUE_BITS];
      end
      if (sel_oh[w]) begin
        key_row_wr[w*KEY_BITS +: KEY_BITS]       = key_r;
        val_row_wr[w*VALUE_BITS +: VALUE_BITS]   = val_r;
      end
    end
  end

  // request decode
  always_comb begin
    valid_row_nxt = valid_row;
    key_we        = 1'b0;
    val_we        = 1'b0;
    clear_all     = 1'b0;
    count_nxt     = count_r;
    status        = STS_NOT_FOUND;
    unique case (op_r)
      OP_INSERT: begin
        if (|hit) begin
          val_we = 1'b1;
          status = STS_UPDATED;
        end else if (|free_oh) begin
          valid_row_nxt = valid_row | free_oh;
          key_we        = 1'b1;
          val_we        = 1'b1;
          count_nxt     = count_r + 1'b1;
          status        = STS_INSERTED;
        end else begin
          status = STS_FULL;
        end
      end
      OP_LOOKUP: begin
        if (|hit) begin
          status = STS_FOUND;
        end
      end
      OP_REMOVE: begin
        if (|hit) begin
          valid_row_nxt = valid_row & ~hit_oh;
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
          status = STS_REMOVED;
        end
      end
      OP_CLEAR: begin
        clear_all = 1'b1;
        count_nxt = '0;
        status    = STS_CLEARED;
      end
      default: status = STS_NOT_FOUND;
    endcase

    rsp_nxt.status      = status;
    rsp_nxt.found_value = (status == STS_FOUND) ? VALUE_W'(found) : '0;
    rsp_nxt.entry_count = COUNT_W'(count_nxt);
    rsp_nxt.table_empty = (count_nxt == '0);
  end

  // valid bits and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BUCKETS; b++) begin
        valid_r[b] <= '0;
      end
      count_r <= '0;
    end else if (cmd.exec) begin
      if (clear_all) begin
        for (int b = 0; b < BUCKETS; b++) begin
          valid_r[b] <= '0;
        end
      end else begin
        valid_r[bucket_r] <= valid_row_nxt;
      end
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= rsp_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ sim/chained_hash_table_kv_test.sv @@
`timescale 1ns / 1ps

module chained_hash_table_kv_test;
  import chtkv_pkg::*;

  localparam int NB    = BUCKETS_DEF;
  localparam int NW    = WAYS_DEF;
  localparam int SLOTS = NB * NW;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  req_t in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  // predicted table contents
  logic [KEY_W-1:0]   tbl_key [SLOTS];
  logic [VALUE_W-1:0] tbl_val [SLOTS];
  bit                 tbl_used [SLOTS];
  int                 tbl_count;

  req_t             request_queue [$];
  rsp_t             expected_results [$];
  rsp_t             oldest_expected;
  logic [KEY_W-1:0] key_pool [$];
  int               send_idle_pct;
  int               recv_idle_pct;
  int               bad_results;

  chained_hash_table_kv u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic req_t make_req(op_e_t op, logic [KEY_W-1:0] key,
                                    logic [VALUE_W-1:0] val);
    req_t req;
    req.req_type  = op;
    req.req_key   = key;
    req.req_value = val;
    return req;
  endfunction

  // apply one request to the predicted table and return its result
  function automatic rsp_t apply_to_table(req_t req);
    rsp_t rsp;
    int   base;
    int   hit;
    int   free_slot;
    rsp       = '0;
    hit       = -1;
    free_slot = -1;
    base      = int'(64'(req.req_key) % 64'(NB)) * NW;
    for (int w = 0; w < NW; w++) begin
      if (tbl_used[base + w] && tbl_key[base + w] == req.req_key && hit < 0) hit = base + w;
      if (!tbl_used[base + w] && free_slot < 0) free_slot = base + w;
    end
    case (req.req_type)
      OP_INSERT: begin
        if (hit >= 0) begin
          tbl_val[hit] = req.req_value;
          rsp.status   = STS_UPDATED;
        end else if (free_slot >= 0) begin
          tbl_used[free_slot] = 1'b1;
          tbl_key[free_slot]  = req.req_key;
          tbl_val[free_slot]  = req.req_value;
          tbl_count++;
          rsp.status = STS_INSERTED;
        end else begin
          rsp.status = STS_FULL;
        end
      end
      OP_LOOKUP: begin
        if (hit >= 0) begin
          rsp.status      = STS_FOUND;
          rsp.found_value = tbl_val[hit];
        end else begin
          rsp.status = STS_NOT_FOUND;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          tbl_used[hit] = 1'b0;
          if (tbl_count > 0) tbl_count--;
          rsp.status = STS_REMOVED;
        end else begin
          rsp.status = STS_NOT_FOUND;
        end
      end
      default: begin
        for (int s = 0; s < SLOTS; s++) tbl_used[s] = 1'b0;
        tbl_count  = 0;
        rsp.status = STS_CLEARED;
      end
    endcase
    rsp.entry_count = COUNT_W'(tbl_count);
    rsp.table_empty = (tbl_count == 0);
    return rsp;
  endfunction

  // clear, fill every bucket past its ways, then a mix of requests on those keys
  task automatic queue_random_phase(int mixed_items);
    logic [KEY_W-1:0] key;
    int               pick;
    key_pool.delete();
    request_queue.push_back(make_req(OP_CLEAR, $urandom, $urandom));
    for (int b = 0; b < NB; b++) begin
      for (int w = 0; w <= NW; w++) begin
        key = {28'($urandom_range(32'h0fff_ffff, 0)), 4'(b)};
        key_pool.push_back(key);
        request_queue.push_back(make_req(OP_INSERT, key, $urandom));
      end
    end
    for (int i = 0; i < mixed_items; i++) begin
      pick = $urandom_range(99);
      key  = ($urandom_range(9) == 0) ? $urandom
                                      : key_pool[$urandom_range(key_pool.size() - 1)];
      if (pick < 40) begin
        request_queue.push_back(make_req(OP_INSERT, key, $urandom));
      end else if (pick < 65) begin
        request_queue.push_back(make_req(OP_LOOKUP, key, $urandom));
      end else if (pick < 88) begin
        request_queue.push_back(make_req(OP_REMOVE, key, $urandom));
      end else if (pick < 90) begin
        request_queue.push_back(make_req(OP_CLEAR, key, $urandom));
      end else begin
        // noise: any request type, unrelated key
        request_queue.push_back(make_req(op_e_t'(TYPE_W'($urandom_range(3))),
                                         $urandom, $urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (request_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // stimulus sequencing
  initial begin
    tbl_count = 0;
    for (int s = 0; s < SLOTS; s++) begin
      tbl_used[s] = 1'b0;
      tbl_key[s]  = '0;
      tbl_val[s]  = '0;
    end
    bad_results   = 0;
    send_idle_pct = 38;
    recv_idle_pct = 61;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extreme keys and values, full bucket, clear
    request_queue.push_back(make_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000));
    request_queue.push_back(make_req(OP_REMOVE, 32'hffff_ffff, 32'hffff_ffff));
    request_queue.push_back(make_req(OP_INSERT, 32'h0000_0000, 32'hffff_ffff));
    request_queue.push_back(make_req(OP_INSERT, 32'hffff_ffff, 32'h0000_0000));
    request_queue.push_back(make_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000));
    request_queue.push_back(make_req(OP_LOOKUP, 32'hffff_ffff, 32'hffff_ffff));
    request_queue.push_back(make_req(OP_INSERT, 32'h0000_0000, 32'h1234_5678));
    request_queue.push_back(make_req(OP_INSERT, 32'h0000_0010, 32'h0000_0001));
    request_queue.push_back(make_req(OP_INSERT, 32'h0000_0020, 32'h0000_0002));
    request_queue.push_back(make_req(OP_INSERT, 32'h0000_0030, 32'h0000_0003));
    request_queue.push_back(make_req(OP_INSERT, 32'h0000_0040, 32'h0000_0004));
    request_queue.push_back(make_req(OP_INSERT, 32'h0000_0020, 32'ha5a5_a5a5));
    request_queue.push_back(make_req(OP_LOOKUP, 32'h0000_0040, 32'h0000_0000));
    request_queue.push_back(make_req(OP_LOOKUP, 32'h0000_0020, 32'h0000_0000));
    request_queue.push_back(make_req(OP_REMOVE, 32'h0000_0010, 32'h0000_0000));
    request_queue.push_back(make_req(OP_REMOVE, 32'h0000_0010, 32'h0000_0000));
    request_queue.push_back(make_req(OP_INSERT, 32'h0000_0040, 32'h5a5a_5a5a));
    request_queue.push_back(make_req(OP_LOOKUP, 32'h0000_0040, 32'h0000_0000));
    request_queue.push_back(make_req(OP_CLEAR,  32'h0000_0000, 32'h0000_0000));
    request_queue.push_back(make_req(OP_LOOKUP, 32'h0000_0020, 32'h0000_0000));
    request_queue.push_back(make_req(OP_CLEAR,  32'hffff_ffff, 32'hffff_ffff));
    request_queue.push_back(make_req(OP_INSERT, 32'h8000_0000, 32'h8000_0001));
    request_queue.push_back(make_req(OP_REMOVE, 32'h8000_0000, 32'h0000_0000));

    // sender idles less than receiver
    queue_random_phase(430);
    wait_drained();

    // receiver idles less than sender
    send_idle_pct = 61;
    recv_idle_pct = 38;
    queue_random_phase(430);
    wait_drained();

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_phase(430);
    wait_drained();

    repeat (20) @(posedge clk);
    if (bad_results == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // request driver, predicts each item as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(apply_to_table(in_data));
      if (!in_valid || in_ready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= request_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("result with none expected: status %0d value %h count %0d empty %b",
                     out_data.status, out_data.found_value, out_data.entry_count,
                     out_data.table_empty);
        end else begin
          oldest_expected = expected_results.pop_front();
          if (out_data.status !== oldest_expected.status ||
              out_data.found_value !== oldest_expected.found_value ||
              out_data.entry_count !== oldest_expected.entry_count ||
              out_data.table_empty !== oldest_expected.table_empty) begin
            bad_results++;
            if (bad_results <= 10)
              $display("mismatch: expected status %0d value %h count %0d empty %b, got %0d %h %0d %b",
                       oldest_expected.status, oldest_expected.found_value,
                       oldest_expected.entry_count, oldest_expected.table_empty,
                       out_data.status, out_data.found_value, out_data.entry_count,
                       out_data.table_empty);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

endmodule
